FILE: design/fsg_pkg.sv
package fsg_pkg;

	localparam int GRID_SIZE = 64;
	localparam int IDX_W = $clog2(GRID_SIZE);
	localparam int FIELD_W = 6;
	localparam int CHK_W = ((IDX_W > FIELD_W) ? IDX_W : FIELD_W) + 1;

	localparam int LFSR_W = 16;
	localparam logic [LFSR_W-1:0] SEED_DEFAULT = 16'd44257;
	localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

	localparam logic [1:0] CMD_MARK = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_PASS = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [GRID_SIZE-1:0] row_t;

	typedef struct packed {
		logic [1:0] command;
		logic [FIELD_W-1:0] cell_row;
		logic [FIELD_W-1:0] cell_column;
	} cmd_t;

	typedef struct packed {
		logic cell_occupied;
		logic status;
	} rsp_t;

	// where an occupied cell goes
	typedef enum logic [1:0] {
		MOVE_DOWN = 2'd0,
		MOVE_LEFT = 2'd1,
		MOVE_RIGHT = 2'd2
	} move_t;

	typedef struct packed {
		logic moved;
		move_t dir;
		logic tie;
	} settle_t;

endpackage

FILE: design/falling_sand_grid_step.sv
// Falling-sand grid of 64 by 64 occupied bits, empty after reset (per-row valid
// flags, so no clearing sweep). Commands on cmd: mark a cell, read a cell, or
// run one in-place update pass; each returns exactly one response on rsp.
// Mark and read do one row read, and mark then one row write, on the row
// memory, which has separate read and write ports. In a pass, each row is
// loaded into a working register and one shared settle unit handles one
// column per cycle, with a load state and a write-back state per row.
// cmd_ready is low while a command is in progress. A cfg_we write reloads
// the tie-break LFSR (zero loads 44257); write it only while idle.
module falling_sand_grid_step (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  fsg_pkg::cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output fsg_pkg::rsp_t rsp,
	input  logic cfg_we,
	input  logic [fsg_pkg::LFSR_W-1:0] cfg_wdata
);

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_RMW_RD   = 9'b000000010,
		ST_RMW_DATA = 9'b000000100,
		ST_P_RD_BLW = 9'b000001000,
		ST_P_RD_CUR = 9'b000010000,
		ST_P_LOAD   = 9'b000100000,
		ST_P_SCAN   = 9'b001000000,
		ST_P_WR_BLW = 9'b010000000,
		ST_DONE     = 9'b100000000
	} state_t;

	localparam fsg_pkg::idx_t LAST_IDX = fsg_pkg::IDX_W'(fsg_pkg::GRID_SIZE - 1);
	localparam fsg_pkg::idx_t START_ROW = fsg_pkg::IDX_W'(fsg_pkg::GRID_SIZE - 2);
	localparam fsg_pkg::idx_t IDX_ONE = fsg_pkg::IDX_W'(1);

	state_t state_q;
	logic [1:0] cmd_q;
	fsg_pkg::idx_t row_q;
	fsg_pkg::idx_t col_q;
	logic occ_q;
	logic status_q;
	fsg_pkg::row_t cur_q;
	fsg_pkg::row_t blw_q;
	logic [fsg_pkg::LFSR_W-1:0] lfsr_q;
	logic rsp_valid_q;
	fsg_pkg::rsp_t rsp_q;

	logic rd_en;
	fsg_pkg::idx_t rd_addr;
	fsg_pkg::row_t rd_data;
	logic wr_en;
	fsg_pkg::idx_t wr_addr;
	fsg_pkg::row_t wr_data;

	logic in_range;
	fsg_pkg::idx_t col_lt;
	fsg_pkg::idx_t col_rt;
	fsg_pkg::idx_t row_dn;
	fsg_pkg::settle_t settle;
	fsg_pkg::idx_t tgt_col;
	logic [fsg_pkg::LFSR_W-1:0] seed_val;

	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign in_range =
		(fsg_pkg::CHK_W'(cmd.cell_row) < fsg_pkg::CHK_W'(fsg_pkg::GRID_SIZE)) &&
		(fsg_pkg::CHK_W'(cmd.cell_column) < fsg_pkg::CHK_W'(fsg_pkg::GRID_SIZE));

	assign col_lt = col_q - IDX_ONE;
	assign col_rt = col_q + IDX_ONE;
	assign row_dn = row_q + IDX_ONE;
	assign seed_val = (cfg_wdata == '0) ? fsg_pkg::SEED_DEFAULT : cfg_wdata;

	fsg_settle_unit u_settle (
		.occ(cur_q[col_q]),
		.below(blw_q[col_q]),
		.below_left(blw_q[col_lt]),
		.below_right(blw_q[col_rt]),
		.at_left(col_q == '0),
		.at_right(col_q == LAST_IDX),
		.lfsr_bit(lfsr_q[0]),
		.res(settle)
	);

	always_comb begin
		case (settle.dir)
			fsg_pkg::MOVE_LEFT:  tgt_col = col_lt;
			fsg_pkg::MOVE_RIGHT: tgt_col = col_rt;
			default:             tgt_col = col_q;
		endcase
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = row_q;
		wr_en = 1'b0;
		wr_addr = row_q;
		wr_data = rd_data | (fsg_pkg::row_t'(1) << col_q);
		unique case (state_q)
			ST_RMW_RD: rd_en = 1'b1;
			ST_RMW_DATA: wr_en = (cmd_q == fsg_pkg::CMD_MARK);
			ST_P_RD_BLW: begin
				rd_en = 1'b1;
				rd_addr = row_dn;
			end
			ST_P_RD_CUR: rd_en = 1'b1;
			ST_P_WR_BLW: begin
				wr_en = 1'b1;
				wr_addr = row_dn;
				wr_data = blw_q;
				rd_en = (row_q != '0);
				rd_addr = row_q - IDX_ONE;
			end
			ST_DONE: begin
				// row 0 write-back at the end of a pass
				wr_en = (cmd_q == fsg_pkg::CMD_PASS) && !rsp_valid_q;
				wr_data = cur_q;
			end
			default: ;
		endcase
	end

	fsg_row_mem u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_P_RD_CUR: blw_q <= rd_data;
			ST_P_LOAD: cur_q <= rd_data;
			ST_P_SCAN: begin
				if (settle.moved) begin
					cur_q[col_q] <= 1'b0;
					blw_q[tgt_col] <= 1'b1;
				end
			end
			ST_P_WR_BLW: blw_q <= cur_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q <= fsg_pkg::CMD_MARK;
			row_q <= '0;
			col_q <= '0;
			occ_q <= 1'b0;
			status_q <= 1'b0;
			lfsr_q <= fsg_pkg::SEED_DEFAULT;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				lfsr_q <= seed_val;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd.command;
						occ_q <= 1'b0;
						col_q <= fsg_pkg::IDX_W'(cmd.cell_column);
						case (cmd.command) inside
							fsg_pkg::CMD_MARK, fsg_pkg::CMD_READ: begin
								row_q <= fsg_pkg::IDX_W'(cmd.cell_row);
								status_q <= !in_range;
								if (in_range) begin
									state_q <= ST_RMW_RD;
								end else begin
									state_q <= ST_DONE;
								end
							end
							fsg_pkg::CMD_PASS: begin
								row_q <= START_ROW;
								status_q <= 1'b0;
								state_q <= ST_P_RD_BLW;
							end
							default: begin
								status_q <= 1'b0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_RMW_RD: state_q <= ST_RMW_DATA;
				ST_RMW_DATA: begin
					if (cmd_q == fsg_pkg::CMD_READ) begin
						occ_q <= rd_data[col_q];
					end
					state_q <= ST_DONE;
				end
				ST_P_RD_BLW: state_q <= ST_P_RD_CUR;
				ST_P_RD_CUR: state_q <= ST_P_LOAD;
				ST_P_LOAD: begin
					col_q <= '0;
					state_q <= ST_P_SCAN;
				end
				ST_P_SCAN: begin
					// advance the LFSR only when both diagonals were free
					if (settle.tie) begin
						lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? fsg_pkg::LFSR_MASK : '0);
					end
					col_q <= col_rt;
					if (col_q == LAST_IDX) begin
						state_q <= ST_P_WR_BLW;
					end
				end
				ST_P_WR_BLW: begin
					if (row_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						row_q <= row_q - IDX_ONE;
						state_q <= ST_P_LOAD;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q) begin
						rsp_valid_q <= 1'b1;
						rsp_q.cell_occupied <= occ_q;
						rsp_q.status <= status_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: design/fsg_row_mem.sv
module fsg_row_mem (
	input  logic clk,
	input  logic arst_n,
	input  logic rd_en,
	input  fsg_pkg::idx_t rd_addr,
	output fsg_pkg::row_t rd_data,
	input  logic wr_en,
	input  fsg_pkg::idx_t wr_addr,
	input  fsg_pkg::row_t wr_data
);

	fsg_pkg::row_t mem [fsg_pkg::GRID_SIZE];
	logic [fsg_pkg::GRID_SIZE-1:0] row_vld_q;
	fsg_pkg::row_t rd_data_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// a row never written reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: design/fsg_settle_unit.sv
module fsg_settle_unit (
	input  logic occ,
	input  logic below,
	input  logic below_left,
	input  logic below_right,
	input  logic at_left,
	input  logic at_right,
	input  logic lfsr_bit,
	output fsg_pkg::settle_t res
);

	logic left_free;
	logic right_free;

	assign left_free = !at_left && !below_left;
	assign right_free = !at_right && !below_right;

	always_comb begin
		res.moved = 1'b0;
		res.dir = fsg_pkg::MOVE_DOWN;
		res.tie = 1'b0;
		if (occ) begin
			if (!below) begin
				res.moved = 1'b1;
			end else if (left_free && right_free) begin
				res.moved = 1'b1;
				res.tie = 1'b1;
				res.dir = lfsr_bit ? fsg_pkg::MOVE_RIGHT : fsg_pkg::MOVE_LEFT;
			end else if (left_free) begin
				res.moved = 1'b1;
				res.dir = fsg_pkg::MOVE_LEFT;
			end else if (right_free) begin
				res.moved = 1'b1;
				res.dir = fsg_pkg::MOVE_RIGHT;
			end
		end
	end

endmodule
